// ===== rtl/trp_pkg.sv =====
// shared types, constants and register indexes for the tablet packet receiver
// no dependencies
package trp_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned ID_W     = 4;
	localparam int unsigned COORD_W  = 6;
	localparam int unsigned THR_W    = 8;
	localparam int unsigned PHASE_W  = 3;
	localparam int unsigned CFG_IDX_W = 2;

	localparam int unsigned IN_TDATA_W  = 40;
	localparam int unsigned OUT_TDATA_W = 96;

	localparam int unsigned SYNC_BIT = 6;
	localparam int unsigned ID_LSB   = 2;

	// packet byte positions
	localparam logic [PHASE_W-1:0] PH_SYNC = 3'd0;
	localparam logic [PHASE_W-1:0] PH_XHI  = 3'd1;
	localparam logic [PHASE_W-1:0] PH_XLO  = 3'd2;
	localparam logic [PHASE_W-1:0] PH_YHI  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_YLO  = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INIT_THR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THR_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THR_CEIL = 2'd2;

	localparam logic [THR_W-1:0] INIT_THR_RST = 8'd1;
	localparam logic [THR_W-1:0] THR_STEP_RST = 8'd1;
	localparam logic [THR_W-1:0] THR_CEIL_RST = 8'd16;

	typedef struct packed {
		logic [BYTE_W-1:0] rx_byte;
		logic [TIME_W-1:0] time_now;
		logic              queue_has_room;
	} in_item_t;

	typedef struct packed {
		logic [ID_W-1:0]    device_id;
		logic [COORD_W-1:0] x_upper;
		logic [COORD_W-1:0] x_lower;
		logic [COORD_W-1:0] y_upper;
		logic [COORD_W-1:0] y_lower;
		logic [TIME_W-1:0]  stamp;
		logic [TIME_W-1:0]  time_delta;
	} sample_t;

	typedef struct packed {
		logic [THR_W-1:0] initial_threshold;
		logic [THR_W-1:0] threshold_step;
		logic [THR_W-1:0] threshold_ceiling;
	} cfg_t;

endpackage

// ===== rtl/trp_in_stage.sv =====
// input register stage: holds one accepted byte transfer for the packet core
// depends on trp_pkg
module trp_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  trp_pkg::in_item_t in_item,
	input  logic              advance,
	output logic              valid_s1,
	output trp_pkg::in_item_t item_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== rtl/trp_core.sv =====
// packet assembly, duplicate test and threshold tracking, one byte per cycle unless stalled
// depends on trp_pkg
module trp_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  trp_pkg::in_item_t item_s1,
	input  trp_pkg::cfg_t     cfg,
	output logic              res_valid,
	output trp_pkg::sample_t  res
);

	logic [trp_pkg::PHASE_W-1:0] phase_q;
	logic [trp_pkg::ID_W-1:0]    cur_id_q;
	logic [trp_pkg::ID_W-1:0]    prev_id_q;
	logic [trp_pkg::COORD_W-1:0] cur_q  [4];
	logic [trp_pkg::COORD_W-1:0] prev_q [4];
	logic [trp_pkg::THR_W-1:0]   thr_q;
	logic [trp_pkg::TIME_W-1:0]  last_time_q;

	logic                        waiting;
	logic                        last_byte;
	logic [trp_pkg::COORD_W-1:0] coord;
	logic [trp_pkg::THR_W-1:0]   x_gap;
	logic [trp_pkg::THR_W-1:0]   y_gap;
	logic                        dup;
	logic [trp_pkg::THR_W:0]     thr_sum;
	logic [trp_pkg::THR_W-1:0]   thr_next;

	function automatic logic [trp_pkg::THR_W-1:0] gap(
		input logic [trp_pkg::COORD_W-1:0] a,
		input logic [trp_pkg::COORD_W-1:0] b
	);
		logic [trp_pkg::COORD_W-1:0] d;
		d = (a >= b) ? (a - b) : (b - a);
		return {{(trp_pkg::THR_W-trp_pkg::COORD_W){1'b0}}, d};
	endfunction

	assign waiting   = (phase_q == trp_pkg::PH_SYNC) || (phase_q > trp_pkg::PH_YLO);
	assign last_byte = (phase_q == trp_pkg::PH_YLO);
	assign coord     = item_s1.rx_byte[trp_pkg::COORD_W-1:0];

	assign x_gap = gap(prev_q[0], cur_q[0]);
	assign y_gap = gap(prev_q[2], cur_q[2]);
	assign dup   = (prev_id_q == cur_id_q) && (x_gap <= thr_q) && (prev_q[1] == cur_q[1])
		&& (y_gap <= thr_q) && (prev_q[3] == coord);

	assign thr_sum  = {1'b0, thr_q} + {1'b0, cfg.threshold_step};
	assign thr_next = (thr_sum > {1'b0, cfg.threshold_ceiling}) ? cfg.threshold_ceiling
		: thr_sum[trp_pkg::THR_W-1:0];

	assign res_valid = step && !waiting && last_byte && !dup && item_s1.queue_has_room;

	always_comb begin
		res.device_id  = cur_id_q;
		res.x_upper    = cur_q[0];
		res.x_lower    = cur_q[1];
		res.y_upper    = cur_q[2];
		res.y_lower    = coord;
		res.stamp      = item_s1.time_now;
		res.time_delta = item_s1.time_now - last_time_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= trp_pkg::PH_SYNC;
			cur_id_q    <= '0;
			prev_id_q   <= '0;
			thr_q       <= trp_pkg::INIT_THR_RST;
			last_time_q <= '0;
			for (int i = 0; i < 4; i++) begin
				cur_q[i]  <= '0;
				prev_q[i] <= '0;
			end
		end else if (step) begin
			if (waiting) begin
				if (item_s1.rx_byte[trp_pkg::SYNC_BIT]) begin
					prev_id_q <= cur_id_q;
					for (int i = 0; i < 4; i++) begin
						prev_q[i] <= cur_q[i];
					end
					cur_id_q <= item_s1.rx_byte[trp_pkg::ID_LSB +: trp_pkg::ID_W];
					phase_q  <= trp_pkg::PH_XHI;
				end else begin
					phase_q <= trp_pkg::PH_SYNC;
				end
			end else begin
				cur_q[2'(phase_q - trp_pkg::PH_XHI)] <= coord;
				if (last_byte) begin
					phase_q     <= trp_pkg::PH_SYNC;
					last_time_q <= item_s1.time_now;
					if (!dup && item_s1.queue_has_room) begin
						thr_q <= cfg.initial_threshold;
					end else begin
						thr_q <= thr_next;
					end
				end else begin
					phase_q <= phase_q + 3'd1;
				end
			end
		end
	end

endmodule

// ===== rtl/trp_out_reg.sv =====
// result register: holds one sample until the downstream side takes it
// depends on trp_pkg
module trp_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_valid,
	input  trp_pkg::sample_t res,
	output logic             advance,
	output logic             out_valid,
	input  logic             out_ready,
	output trp_pkg::sample_t out_sample
);

	logic             valid_q;
	trp_pkg::sample_t sample_q;

	assign advance    = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign out_sample = sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			sample_q <= res;
		end
	end

endmodule

// ===== rtl/tablet_packet_receiver.sv =====
// tablet packet receiver: turns a stream of tablet bytes into position samples
// depends on trp_pkg, trp_in_stage, trp_core, trp_out_reg
//
// usage:
//   s_axis carries one tablet byte per transfer together with its 32-bit time
//   and, in tuser, whether the downstream sample queue has room.
//   m_axis carries one sample per completed, non-duplicate packet with room:
//   id, the four 6-bit coordinate parts, the time stamp and the time since
//   the previous packet. Most bytes give no output.
//   the cfg channel writes initial threshold (0), threshold step (1) and
//   threshold ceiling (2); other indexes are ignored. cfg_ready is always high.
// timing:
//   one byte per cycle sustained while m_axis does not stall. a sample is
//   valid on m_axis after the fifth byte of its packet passes the input
//   register, then the result register behind the combinational assembly logic.
// reset:
//   waits for a sync byte, coordinate history zero, threshold 1, step 1,
//   ceiling 16. a stalled m_axis holds the sample and stalls the byte path
//   once the input register is full.
module tablet_packet_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // rx_byte[7:0], time_now[39:8]
	input  logic        s_axis_tuser,  // queue_has_room
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// device_id[3:0], x_upper[9:4], x_lower[15:10], y_upper[21:16],
	// y_lower[27:22], stamp[59:28], time_delta[91:60], zero[95:92]
	output logic [95:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	trp_pkg::in_item_t in_item;
	trp_pkg::in_item_t item_s1;
	trp_pkg::sample_t  res;
	trp_pkg::sample_t  out_sample;
	trp_pkg::cfg_t     cfg_q;
	logic              valid_s1;
	logic              advance;
	logic              res_valid;

	assign in_item.rx_byte        = s_axis_tdata[7:0];
	assign in_item.time_now       = s_axis_tdata[39:8];
	assign in_item.queue_has_room = s_axis_tuser;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.initial_threshold <= trp_pkg::INIT_THR_RST;
			cfg_q.threshold_step    <= trp_pkg::THR_STEP_RST;
			cfg_q.threshold_ceiling <= trp_pkg::THR_CEIL_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				trp_pkg::REG_INIT_THR: cfg_q.initial_threshold <= cfg_data;
				trp_pkg::REG_THR_STEP: cfg_q.threshold_step    <= cfg_data;
				trp_pkg::REG_THR_CEIL: cfg_q.threshold_ceiling <= cfg_data;
				default: ;
			endcase
		end
	end

	trp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	trp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (valid_s1 && advance),
		.item_s1   (item_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	trp_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_valid  (res_valid),
		.res        (res),
		.advance    (advance),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_sample (out_sample)
	);

	assign m_axis_tdata = {4'b0000, out_sample.time_delta, out_sample.stamp,
		out_sample.y_lower, out_sample.y_upper, out_sample.x_lower, out_sample.x_upper,
		out_sample.device_id};

endmodule

// ===== tb/tb_tablet_packet_receiver.sv =====
// self-checking testbench for tablet_packet_receiver: byte stream in, samples out, cfg writes
// depends on trp_pkg and the rtl top level; a local model predicts every sample
// directed packets first, then randomised phases, most with random gaps and back-pressure
module tb_tablet_packet_receiver;
	import trp_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;  // rx_byte[7:0], time_now[39:8]
	logic        s_axis_tuser = 1'b0;  // queue_has_room
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// device_id[3:0], x_upper[9:4], x_lower[15:10], y_upper[21:16],
	// y_lower[27:22], stamp[59:28], time_delta[91:60], zero[95:92]
	logic [95:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	tablet_packet_receiver uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// local copy of the packet assembler
	logic [THR_W-1:0]   cfg_init = INIT_THR_RST;
	logic [THR_W-1:0]   cfg_step = THR_STEP_RST;
	logic [THR_W-1:0]   cfg_ceil = THR_CEIL_RST;
	logic [PHASE_W-1:0] rx_phase = PH_SYNC;
	logic [ID_W-1:0]    id_now = '0;
	logic [ID_W-1:0]    id_last = '0;
	logic [COORD_W-1:0] coord_now [4] = '{default: '0};
	logic [COORD_W-1:0] coord_last [4] = '{default: '0};
	logic [THR_W-1:0]   thr_now = INIT_THR_RST;
	logic [TIME_W-1:0]  t_last = '0;

	sample_t pending_samples [$];
	int      fail_count = 0;
	int      cycle_count = 0;
	bit      gaps_on = 1'b1;

	// stimulus side history, used to build near-duplicate packets
	logic [TIME_W-1:0]  clock_now = '0;
	logic [ID_W-1:0]    sent_id = '0;
	logic [COORD_W-1:0] sent_xh = '0, sent_xl = '0, sent_yh = '0, sent_yl = '0;

	initial forever #5 clk = ~clk;

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic int coord_gap(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
		return (a >= b) ? int'(a) - int'(b) : int'(b) - int'(a);
	endfunction

	function automatic void predict_byte(logic [7:0] b, logic [TIME_W-1:0] now, logic room);
		sample_t s;
		logic [THR_W:0] sum;
		bit repeat_pos;
		if (rx_phase == PH_SYNC || rx_phase > PH_YLO) begin
			if (!b[SYNC_BIT]) begin
				rx_phase = PH_SYNC;
				return;
			end
			id_last = id_now;
			coord_last = coord_now;
			id_now = b[ID_LSB +: ID_W];
			rx_phase = PH_XHI;
			return;
		end
		coord_now[int'(rx_phase) - 1] = b[COORD_W-1:0];
		if (rx_phase < PH_YLO) begin
			rx_phase = rx_phase + 1'b1;
			return;
		end
		rx_phase = PH_SYNC;
		repeat_pos = (id_last == id_now)
			&& (coord_gap(coord_last[0], coord_now[0]) <= int'(thr_now))
			&& (coord_last[1] == coord_now[1])
			&& (coord_gap(coord_last[2], coord_now[2]) <= int'(thr_now))
			&& (coord_last[3] == coord_now[3]);
		if (!repeat_pos && room) begin
			s.device_id = id_now;
			s.x_upper = coord_now[0];
			s.x_lower = coord_now[1];
			s.y_upper = coord_now[2];
			s.y_lower = coord_now[3];
			s.stamp = now;
			s.time_delta = now - t_last;
			pending_samples.push_back(s);
			thr_now = cfg_init;
		end else begin
			sum = {1'b0, thr_now} + {1'b0, cfg_step};
			if (sum > {1'b0, cfg_ceil})
				sum = {1'b0, cfg_ceil};
			thr_now = sum[THR_W-1:0];
		end
		t_last = now;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// sample receiver with random stalls
	initial begin
		int stall;
		sample_t want;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = gaps_on ? $urandom_range(0, 6) : 0;
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
			if (pending_samples.size() == 0) begin
				$error("sample with no expectation waiting: tdata %h", m_axis_tdata);
				fail_count++;
			end else begin
				want = pending_samples.pop_front();
				check_field("device_id", 32'(want.device_id), 32'(m_axis_tdata[3:0]));
				check_field("x_upper", 32'(want.x_upper), 32'(m_axis_tdata[9:4]));
				check_field("x_lower", 32'(want.x_lower), 32'(m_axis_tdata[15:10]));
				check_field("y_upper", 32'(want.y_upper), 32'(m_axis_tdata[21:16]));
				check_field("y_lower", 32'(want.y_lower), 32'(m_axis_tdata[27:22]));
				check_field("stamp", want.stamp, m_axis_tdata[59:28]);
				check_field("time_delta", want.time_delta, m_axis_tdata[91:60]);
			end
		end
	end

	function automatic logic [TIME_W-1:0] tick_clock();
		if ($urandom_range(0, 49) == 0)
			clock_now = $urandom;
		else
			clock_now = clock_now + $urandom_range(1, 2000);
		return clock_now;
	endfunction

	task automatic send_byte(logic [7:0] b, logic [TIME_W-1:0] t, logic room);
		int gap;
		@(negedge clk);
		gap = gaps_on ? $urandom_range(0, 6) : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {t, b};
		s_axis_tuser <= room;
		do @(posedge clk); while (!s_axis_tready);
		predict_byte(b, t, room);
	endtask

	// sync byte plus four coordinate bytes; the top two bits of each coordinate byte are junk
	task automatic send_packet(logic [ID_W-1:0] id, logic [COORD_W-1:0] xh,
			logic [COORD_W-1:0] xl, logic [COORD_W-1:0] yh, logic [COORD_W-1:0] yl,
			logic room);
		logic [7:0] b [5];
		logic [COORD_W-1:0] c [4];
		logic [3:0] junk;
		junk = 4'($urandom);
		c = '{xh, xl, yh, yl};
		b[0] = {junk[3], 1'b1, id, junk[1:0]};
		for (int i = 0; i < 4; i++) begin
			junk = 4'($urandom);
			b[i+1] = {junk[1:0], c[i]};
		end
		for (int i = 0; i < 5; i++)
			send_byte(b[i], tick_clock(), (i == 4) ? room : logic'($urandom_range(0, 1)));
		sent_id = id;
		sent_xh = xh;
		sent_xl = xl;
		sent_yh = yh;
		sent_yl = yl;
	endtask

	task automatic drain_pipeline();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_samples.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic load_config(logic [THR_W-1:0] init, logic [THR_W-1:0] step,
			logic [THR_W-1:0] ceil);
		logic [CFG_IDX_W-1:0] idx [4];
		logic [THR_W-1:0] val [4];
		idx = '{REG_SPARE, REG_INIT_THR, REG_THR_STEP, REG_THR_CEIL};
		val = '{THR_W'($urandom), init, step, ceil};
		for (int i = 0; i < 4; i++) begin
			@(negedge clk);
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
			case (idx[i])
				REG_INIT_THR: cfg_init = val[i];
				REG_THR_STEP: cfg_step = val[i];
				REG_THR_CEIL: cfg_ceil = val[i];
				default: ;
			endcase
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_directed_packets();
		// non-sync bytes while waiting are ignored
		send_byte(8'h00, 32'h0000_0000, 1'b0);
		send_byte(8'hbf, 32'hffff_ffff, 1'b1);
		// all-zero packet repeats the reset history
		send_packet(4'd0, 6'd0, 6'd0, 6'd0, 6'd0, 1'b1);
		// top id and coordinates; the sync bit inside the packet is random junk
		send_packet(4'd15, 6'd63, 6'd63, 6'd63, 6'd63, 1'b1);
		// high part moves within the threshold, lows equal
		send_packet(4'd15, 6'd62, 6'd63, 6'd63, 6'd63, 1'b1);
	endtask

	task automatic test_threshold_registers();
		drain_pipeline();
		// initial threshold above the ceiling
		load_config(8'd200, 8'd5, 8'd10);
		clock_now = 32'hffff_fff0;
		send_packet(4'd3, 6'd10, 6'd20, 6'd30, 6'd40, 1'b0);
		// clock wraps between packets
		send_packet(4'd3, 6'd50, 6'd21, 6'd1, 6'd40, 1'b1);
		send_packet(4'd3, 6'd50, 6'd21, 6'd3, 6'd40, 1'b1);
	endtask

	task automatic test_random_traffic();
		int sent;
		int pick;
		int span;
		int burst;
		int xh, yh;
		logic [ID_W-1:0] id;
		logic [COORD_W-1:0] xl, yl;
		for (int phase = 0; phase < 9; phase++) begin
			drain_pipeline();
			if (phase == 0)
				load_config(8'd0, 8'd0, 8'd0);
			else if (phase == 1)
				load_config(8'd255, 8'd255, 8'd255);
			else if (phase % 3 == 0)
				load_config(THR_W'($urandom_range(0, 8)), THR_W'($urandom_range(0, 4)),
					THR_W'($urandom_range(0, 40)));
			else if (phase % 3 == 1)
				load_config(THR_W'($urandom), THR_W'($urandom), THR_W'($urandom));
			else
				load_config(THR_W'($urandom_range(0, 1) * 255),
					THR_W'($urandom_range(0, 1) * 255),
					THR_W'($urandom_range(0, 1) * 255));
			gaps_on = (phase != 2 && phase != 6);
			sent = 0;
			while (sent < 150) begin
				pick = $urandom_range(0, 9);
				if (pick < 2) begin
					burst = $urandom_range(1, 3);
					repeat (burst)
						send_byte(8'($urandom), tick_clock(), 1'($urandom_range(0, 1)));
					sent += burst;
				end else begin
					if (pick < 6) begin
						span = $urandom_range(0, 20);
						xh = int'(sent_xh) + $urandom_range(0, 2 * span) - span;
						yh = int'(sent_yh) + $urandom_range(0, 2 * span) - span;
						xh = (xh < 0) ? 0 : (xh > 63) ? 63 : xh;
						yh = (yh < 0) ? 0 : (yh > 63) ? 63 : yh;
						id = ($urandom_range(0, 7) == 0) ? ID_W'($urandom) : sent_id;
						xl = sent_xl;
						yl = sent_yl;
						if ($urandom_range(0, 5) == 0)
							xl[$urandom_range(0, COORD_W-1)] ^= 1'b1;
						if ($urandom_range(0, 5) == 0)
							yl[$urandom_range(0, COORD_W-1)] ^= 1'b1;
						send_packet(id, COORD_W'(xh), xl, COORD_W'(yh), yl,
							$urandom_range(0, 3) != 0);
					end else begin
						send_packet(ID_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
							COORD_W'($urandom), COORD_W'($urandom),
							$urandom_range(0, 3) != 0);
					end
					sent += 5;
				end
			end
		end
	endtask

	initial begin
		@(posedge arst_n);
		test_directed_packets();
		test_threshold_registers();
		test_random_traffic();
		drain_pipeline();
		if (fail_count == 0 && pending_samples.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
